// ----- rtl/bilu_pkg.sv -----
// Shared types, widths and constants of the bilinear upscaler.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bilu_pkg;

  localparam int PX_W       = 24;
  localparam int CH_W       = 8;
  localparam int ROW_W      = 12;
  localparam int OUT_X_W    = 12;
  localparam int OUT_Y_W    = 14;
  localparam int SC_W       = 3;
  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = 12;
  localparam int WGT_W      = 5;

  localparam logic [SC_W-1:0]    MAX_SCALE  = 3'd4;
  localparam logic [CFG_H_W-1:0] MAX_HEIGHT = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd2;

  localparam logic [CFG_W_W-1:0] RST_WIDTH  = 11'd1024;
  localparam logic [CFG_H_W-1:0] RST_HEIGHT = 13'd1024;
  localparam logic [SC_W-1:0]    RST_SCALE  = 3'd4;

  // floor(v / 9) == (v * RECIP9) >> 16 for every v up to 255 * 9.
  localparam logic [12:0] RECIP9 = 13'd7282;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [CFG_W_W-1:0] width;
    logic [CFG_H_W-1:0] height;
    logic [SC_W-1:0]    scale;
  } cfg_t;

  typedef struct packed {
    logic [PX_W-1:0]    a;
    logic [PX_W-1:0]    b;
    logic [PX_W-1:0]    c;
    logic [PX_W-1:0]    d;
    logic [OUT_X_W-1:0] cx;
    logic [ROW_W-1:0]   cy;
    logic [SC_W-1:0]    s;
    logic               last;
  } job_t;

  function automatic logic [CH_W-1:0] chan(input logic [PX_W-1:0] px, input logic [1:0] k);
    logic [CH_W-1:0] r;
    case (k)
      2'd0: r = px[23:16];
      2'd1: r = px[15:8];
      default: r = px[7:0];
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bilu_front.sv -----
// Front end: accepts source pixels, keeps the line buffer and position counters,
// and turns each pixel into up to four tile words. Depends on bilu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bilu_front
  import bilu_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cfg_t            cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [CH_W-1:0] red,
  input  wire logic [CH_W-1:0] green,
  input  wire logic [CH_W-1:0] blue,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output job_t                 push_job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [CFG_H_W-1:0] MAX_W13 = CFG_H_W'(MAX_WIDTH);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic [PX_W-1:0] row_mem [MAX_WIDTH];

  logic             state;
  logic [CW-1:0]    col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [PX_W-1:0]  left_px;
  logic [PX_W-1:0]  al_px;
  logic [PX_W-1:0]  cur_px;
  logic [PX_W-1:0]  above;
  logic [CW-1:0]    x_r;
  logic [ROW_W-1:0] y_r;
  logic [SC_W-1:0]  s_r;
  logic             lc_r;
  logic             lr_r;
  logic [3:0]       mask;
  logic [3:0]       sel;
  logic [3:0]       mask_next;

  logic [CFG_H_W-1:0] w_eff;
  logic [CFG_H_W-1:0] h_eff;
  logic [SC_W-1:0]    s_eff;
  logic               last_col;
  logic               last_row;
  logic               x_nz;
  logic               y_nz;
  logic               in_fire;
  logic               finish;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (cfg.width == '0) begin
      w_eff = CFG_H_W'(1);
    end else if (CFG_H_W'(cfg.width) > MAX_W13) begin
      w_eff = MAX_W13;
    end else begin
      w_eff = CFG_H_W'(cfg.width);
    end
    if (cfg.height == '0) begin
      h_eff = CFG_H_W'(1);
    end else if (cfg.height > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = cfg.height;
    end
    if (cfg.scale == '0) begin
      s_eff = SC_W'(1);
    end else if (cfg.scale > MAX_SCALE) begin
      s_eff = MAX_SCALE;
    end else begin
      s_eff = cfg.scale;
    end
    last_col = CFG_H_W'(col_cnt) >= (w_eff - CFG_H_W'(1));
    last_row = CFG_H_W'(row_cnt) >= (h_eff - CFG_H_W'(1));
    x_nz     = (col_cnt != '0);
    y_nz     = (row_cnt != '0);
  end

  // Tiles in order: upper-left cell, clamped right cell, bottom cell, corner cell.
  always_comb begin
    sel = 4'b0000;
    if (mask[0]) begin
      sel = 4'b0001;
    end else if (mask[1]) begin
      sel = 4'b0010;
    end else if (mask[2]) begin
      sel = 4'b0100;
    end else if (mask[3]) begin
      sel = 4'b1000;
    end
    mask_next = mask & ~sel;

    push_job.s    = s_r;
    push_job.last = (mask_next == 4'b0000);
    case (sel)
      4'b0001: begin
        push_job.a  = al_px;
        push_job.b  = above;
        push_job.c  = left_px;
        push_job.d  = cur_px;
        push_job.cx = OUT_X_W'(x_r) - OUT_X_W'(1);
        push_job.cy = y_r - ROW_W'(1);
      end
      4'b0010: begin
        push_job.a  = above;
        push_job.b  = above;
        push_job.c  = cur_px;
        push_job.d  = cur_px;
        push_job.cx = OUT_X_W'(x_r);
        push_job.cy = y_r - ROW_W'(1);
      end
      4'b0100: begin
        push_job.a  = left_px;
        push_job.b  = cur_px;
        push_job.c  = left_px;
        push_job.d  = cur_px;
        push_job.cx = OUT_X_W'(x_r) - OUT_X_W'(1);
        push_job.cy = y_r;
      end
      default: begin
        push_job.a  = cur_px;
        push_job.b  = cur_px;
        push_job.c  = cur_px;
        push_job.d  = cur_px;
        push_job.cx = OUT_X_W'(x_r);
        push_job.cy = y_r;
      end
    endcase

    push_valid = (state == S_EMIT) && (mask != 4'b0000);
    finish = (state == S_EMIT) &&
             ((mask == 4'b0000) || (push_ready && (mask_next == 4'b0000)));
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      above <= row_mem[col_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      row_mem[x_r] <= cur_px;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_px <= {red, green, blue};
      x_r    <= col_cnt;
      y_r    <= row_cnt;
      s_r    <= s_eff;
      lc_r   <= last_col;
      lr_r   <= last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mask    <= 4'b0000;
      col_cnt <= '0;
      row_cnt <= '0;
      left_px <= '0;
      al_px   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_EMIT;
            mask  <= {last_row && last_col, last_row && x_nz, last_col && y_nz, x_nz && y_nz};
          end
        end
        S_EMIT: begin
          if (push_valid && push_ready) begin
            mask <= mask_next;
          end
          if (finish) begin
            state   <= S_IDLE;
            al_px   <= above;
            left_px <= cur_px;
            if (lc_r) begin
              col_cnt <= '0;
              row_cnt <= lr_r ? '0 : y_r + ROW_W'(1);
            end else begin
              col_cnt <= x_r + CW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bilu_queue.sv -----
// Short word queue of tile jobs between the front and back ends.
// Depends on bilu_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module bilu_queue
  import bilu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire job_t              push_job,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output job_t                   pop_job,
  output logic [QCNT_W-1:0]      count
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + QCNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bilu_back.sv -----
// Back end: walks each tile job pixel by pixel, weights the four corners,
// divides by the squared scale and registers the output word. Depends on bilu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bilu_back
  import bilu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire job_t               pop_job,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [OUT_X_W-1:0]      out_x,
  output logic [OUT_Y_W-1:0]      out_y,
  output logic [CH_W-1:0]         out_red,
  output logic [CH_W-1:0]         out_green,
  output logic [CH_W-1:0]         out_blue,
  output logic                    run_last
);

  job_t            job;
  logic            busy;
  logic [SC_W-1:0] fx;
  logic [SC_W-1:0] fy;
  logic            fx_last;
  logic            fy_last;
  logic            done;
  logic            issue;
  logic            s1_load;
  logic            out_adv;

  logic               s1_valid;
  logic [SUM_W-1:0]   s1_sum [3];
  logic [OUT_X_W-1:0] s1_x;
  logic [OUT_Y_W-1:0] s1_y;
  logic [SC_W-1:0]    s1_s;
  logic               s1_last;

  logic [SUM_W-1:0]   sum_c [3];
  logic [CH_W-1:0]    quo [3];
  logic [OUT_X_W-1:0] px_x;
  logic [OUT_Y_W-1:0] px_y;

  assign out_adv   = !out_valid || out_ready;
  assign s1_load   = !s1_valid || out_adv;
  assign issue     = busy && s1_load;
  assign fx_last   = (fx == job.s - SC_W'(1));
  assign fy_last   = (fy == job.s - SC_W'(1));
  assign done      = fx_last && fy_last;
  assign pop_ready = !busy || (issue && done);

  always_comb begin
    logic [SC_W-1:0]      rx;
    logic [SC_W-1:0]      ry;
    logic [WGT_W-1:0]     wa;
    logic [WGT_W-1:0]     wb;
    logic [WGT_W-1:0]     wc;
    logic [WGT_W-1:0]     wd;
    logic [SUM_W+1:0]     acc;
    logic [OUT_X_W+2:0]   xb;
    logic [ROW_W+2:0]     yb;
    rx = job.s - fx;
    ry = job.s - fy;
    wa = WGT_W'({2'b00, rx} * {2'b00, ry});
    wb = WGT_W'({2'b00, fx} * {2'b00, ry});
    wc = WGT_W'({2'b00, rx} * {2'b00, fy});
    wd = WGT_W'({2'b00, fx} * {2'b00, fy});
    for (int k = 0; k < 3; k++) begin
      acc = (14'(chan(job.a, 2'(k))) * 14'(wa)) + (14'(chan(job.b, 2'(k))) * 14'(wb))
          + (14'(chan(job.c, 2'(k))) * 14'(wc)) + (14'(chan(job.d, 2'(k))) * 14'(wd));
      sum_c[k] = acc[SUM_W-1:0];
    end
    xb = 15'(job.cx) * 15'(job.s);
    yb = 15'(job.cy) * 15'(job.s);
    px_x = xb[OUT_X_W-1:0] + OUT_X_W'(fx);
    px_y = yb[OUT_Y_W-1:0] + OUT_Y_W'(fy);
  end

  always_comb begin
    logic [SUM_W+12:0] prod;
    for (int k = 0; k < 3; k++) begin
      prod = 25'(s1_sum[k]) * 25'(RECIP9);
      case (s1_s)
        3'd1: quo[k] = s1_sum[k][CH_W-1:0];
        3'd2: quo[k] = s1_sum[k][CH_W+1:2];
        3'd3: quo[k] = prod[CH_W+15:16];
        default: quo[k] = s1_sum[k][CH_W+3:4];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job <= pop_job;
    end
    if (issue) begin
      s1_sum  <= sum_c;
      s1_x    <= px_x;
      s1_y    <= px_y;
      s1_s    <= job.s;
      s1_last <= job.last && done;
    end
    if (out_adv && s1_valid) begin
      out_x     <= s1_x;
      out_y     <= s1_y;
      out_red   <= quo[0];
      out_green <= quo[1];
      out_blue  <= quo[2];
      run_last  <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      fx        <= '0;
      fy        <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop_ready) begin
        busy <= pop_valid;
        fx   <= '0;
        fy   <= '0;
      end else if (issue) begin
        if (fx_last) begin
          fx <= '0;
          fy <= fy + SC_W'(1);
        end else begin
          fx <= fx + SC_W'(1);
        end
      end
      if (s1_load) begin
        s1_valid <= issue;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bilinear_image_upscaler_core.sv -----
// Top level of the bilinear upscaler: configuration registers, front end,
// job queue and back end. Depends on bilu_pkg, bilu_front, bilu_queue, bilu_back.
`timescale 1ns / 1ps
`default_nettype none

// Source pixels enter in raster order and each one releases the scale-by-scale
// tiles of every source cell whose corners are now known: none for the first
// row and column, one inside the image, and up to four at the right and bottom
// edges, where neighbors are clamped to the edge pixel. The front end reads the
// line buffer as it registers a pixel and hands one tile word a cycle to a
// four-entry queue while the queue has room; it takes no new pixel until its
// tile words are taken. The back end produces one output pixel a cycle
// unless its output stalls, and loads the next tile in the cycle that issues
// the last pixel of the current one. At scale 2 and above this tile walker sets
// the sustained rate; at scale 1 the front end does. A tile taken from an empty
// queue is loaded into the job register before its first pixel issues. Results
// pass the s1 and output registers, with run_last on the final pixel of each
// input pixel. The line buffer has no clearing pass; the first row only writes
// it. Configuration is written through its own port, which is always ready.
module bilinear_image_upscaler_core
  import bilu_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CH_W-1:0]       red,
  input  wire logic [CH_W-1:0]       green,
  input  wire logic [CH_W-1:0]       blue,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_X_W-1:0]         out_x,
  output logic [OUT_Y_W-1:0]         out_y,
  output logic [CH_W-1:0]            out_red,
  output logic [CH_W-1:0]            out_green,
  output logic [CH_W-1:0]            out_blue,
  output logic                       run_last
);

  cfg_t              cfg;
  logic              push_valid;
  logic              push_ready;
  job_t              push_job;
  logic              pop_valid;
  logic              pop_ready;
  job_t              pop_job;
  logic [QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= RST_WIDTH;
      cfg.height <= RST_HEIGHT;
      cfg.scale  <= RST_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  cfg.width  <= cfg_data[CFG_W_W-1:0];
        REG_HEIGHT: cfg.height <= cfg_data[CFG_H_W-1:0];
        REG_SCALE:  cfg.scale  <= cfg_data[SC_W-1:0];
        default: ;
      endcase
    end
  end

  bilu_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job)
  );

  bilu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .count     (q_count)
  );

  bilu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_job  (pop_job),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue),
    .run_last (run_last)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QDEPTH))
    else $error("tile queue holds more words than its depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("front end ready in the cycle after taking a pixel");

  a_ready_after_last_tile: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_ready && push_job.last) |=> in_ready)
    else $error("front end not ready after handing over its last tile");

endmodule

`default_nettype wire
